/* src/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned VALUE_W     = 21;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded code point handed from the front to the back.
    typedef struct packed {
        logic               pair;   // 4-byte form: emit a surrogate pair
        logic [VALUE_W-1:0] value;  // accumulated code point
    } job_t;

endpackage

/* src/u8u16_front.sv */
// Front end: accepts UTF-8 bytes, accumulates sequences, pushes completed code points.
`timescale 1ns / 1ps

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              q_full,
    output logic              push,
    output job_t              push_job
);

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2,
        KIND_FOUR  = 2'd3
    } kind_t;

    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'h80 + 8'h40 + 8'h20;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;

    logic [1:0]         rem_reg, rem_next;
    kind_t              kind_reg, kind_next;
    logic [VALUE_W-1:0] partial_reg, partial_next;
    logic [VALUE_W-1:0] cont;
    logic [VALUE_W-1:0] cont_shifted;
    logic [VALUE_W-1:0] sum;

    assign s_tready = !q_full;

    always_comb
    begin
        cont = (kind_reg == KIND_FOUR) ? {15'd0, s_tdata[5:0]} : {14'd0, s_tdata[6:0]};
        case (rem_reg)
            2'd2:    cont_shifted = cont << 6;
            2'd3:    cont_shifted = cont << 12;
            default: cont_shifted = cont;
        endcase
        sum = partial_reg + cont_shifted;
    end

    always_comb
    begin
        rem_next       = rem_reg;
        kind_next      = kind_reg;
        partial_next   = partial_reg;
        push           = 1'b0;
        push_job.pair  = 1'b0;
        push_job.value = sum;
        if (s_tvalid && s_tready)
        begin
            if (rem_reg == 2'd0)
            begin
                if (s_tdata < LEAD_TWO)
                begin
                    push           = 1'b1;
                    push_job.value = {13'd0, s_tdata};
                end
                else if (s_tdata < LEAD_THREE)
                begin
                    partial_next = {10'd0, s_tdata[4:0], 6'd0};
                    rem_next     = 2'd1;
                    kind_next    = KIND_TWO;
                end
                else if (s_tdata < LEAD_FOUR)
                begin
                    partial_next = {5'd0, s_tdata[3:0], 12'd0};
                    rem_next     = 2'd2;
                    kind_next    = KIND_THREE;
                end
                else
                begin
                    partial_next = {s_tdata[2:0], 18'd0};
                    rem_next     = 2'd3;
                    kind_next    = KIND_FOUR;
                end
            end
            else
            begin
                partial_next = sum;
                rem_next     = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    // sequence complete: hand the code point to the back end
                    push          = 1'b1;
                    push_job.pair = (kind_reg == KIND_FOUR);
                    kind_next     = KIND_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= 2'd0;
            kind_reg    <= KIND_NONE;
            partial_reg <= '0;
        end
        else
        begin
            rem_reg     <= rem_next;
            kind_reg    <= kind_next;
            partial_reg <= partial_next;
        end
    end

endmodule

/* src/u8u16_queue.sv */
// Short FIFO of decoded code points between the front and back ends.
`timescale 1ns / 1ps

module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/u8u16_back.sv */
// Back end: turns code points into UTF-16 words, holding the trail surrogate.
`timescale 1ns / 1ps

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  job_t              q_head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [UNIT_W-1:0] m_tdata,   // [15:0] code_unit
    output logic              m_tlast    // last_of_run
);

    localparam logic [VALUE_W:0]  SUPP_BASE = 22'h010000;
    localparam logic [UNIT_W-1:0] LEAD_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] TRAIL_BASE = 16'hDC00;

    logic              out_valid_reg, out_valid_next;
    logic [UNIT_W-1:0] out_unit_reg, out_unit_next;
    logic              out_last_reg, out_last_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [UNIT_W-1:0] pend_unit_reg, pend_unit_next;
    logic              advance;
    logic [VALUE_W:0]  diff;
    logic [UNIT_W-1:0] lead_unit;
    logic [UNIT_W-1:0] trail_unit;

    // Signed difference from the supplementary base, shifted right by ten with sign fill.
    assign diff       = {1'b0, q_head.value} - SUPP_BASE;
    assign lead_unit  = {{4{diff[VALUE_W]}}, diff[VALUE_W:10]} + LEAD_BASE;
    assign trail_unit = {6'd0, q_head.value[9:0]} + TRAIL_BASE;

    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && !pend_valid_reg && !q_empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_unit_next   = pend_unit_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next = 1'b1;
                if (q_head.pair)
                begin
                    out_unit_next   = lead_unit;
                    out_last_next   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_unit_next  = trail_unit;
                end
                else
                begin
                    out_unit_next = q_head.value[UNIT_W-1:0];
                    out_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg  <= out_unit_next;
        out_last_reg  <= out_last_next;
        pend_unit_reg <= pend_unit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* src/utf8_to_utf16_decoder_top.sv */
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Slave stream: one UTF-8 byte per word on s_tdata[7:0]; no validation is done.
// Master stream: one UTF-16 code unit per word on m_tdata[15:0]; m_tlast marks
// the final unit caused by an input byte (the trail half of a surrogate pair,
// or the only unit otherwise). Bytes that leave a sequence open emit nothing.
// A byte is taken every cycle while the four-entry code point queue has room:
// the front end accumulates sequences byte by byte; the back end drains the
// queue one unit per cycle while m_tready allows and holds the trail surrogate
// until the lead is taken. A completing byte's code point is registered in
// the queue and then in the output register before it appears on m_tdata.
// When the receiver stalls, the output register holds its word, the queue
// fills, and s_tready drops once it is full; nothing is lost.
// Reset clears the open sequence, the queue and the output register.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [UNIT_W-1:0] m_tdata,   // [15:0] code_unit
    output logic              m_tlast    // last_of_run
);

    logic push;
    job_t push_job;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t q_head;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    u8u16_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
